[rtl/core/multilevel_priority_fifo_defines.svh]
// Assertion macros shared by the multilevel priority FIFO RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge out of reset.
`define MLPF_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("multilevel priority fifo check failed");

// When the trigger holds, the consequence holds in the same cycle.
`define MLPF_ASSERT_IMP(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("multilevel priority fifo check failed");

// When the trigger holds, the consequence holds in the next cycle.
`define MLPF_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("multilevel priority fifo check failed");

`else

`define MLPF_ASSERT_ALWAYS(label, cond)
`define MLPF_ASSERT_IMP(label, trig, cons)
`define MLPF_ASSERT_NEXT(label, trig, cons)

`endif

`endif

[rtl/core/mlpf_pkg.sv]
`default_nettype none

package mlpf_pkg;

	// Operation codes of a request word.
	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_INSPECT = 2'd2
	} op_t;

	// Status codes of a response word.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_RESP
	} state_t;

	// Request word.
	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  priority_req;
		logic [15:0] task_id;
	} req_word_t;

	// Response word.
	typedef struct packed {
		logic [1:0]  status;
		logic        out_valid;
		logic [15:0] out_task_id;
		logic [3:0]  out_priority;
		logic        all_empty;
		logic [7:0]  total_count;
		logic [4:0]  level_count;
	} rsp_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic exec;
		logic read;
		logic load_out;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/core/mlpf_req_if.sv]
`default_nettype none

// Request channel: valid, ready and one request word.
interface mlpf_req_if;
	import mlpf_pkg::*;

	logic      valid;
	logic      ready;
	req_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mlpf_rsp_if.sv]
`default_nettype none

// Response channel: valid, ready and one response word.
interface mlpf_rsp_if;
	import mlpf_pkg::*;

	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mlpf_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module mlpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/mlpf_ctrl.sv]
`default_nettype none

// Sequencer: one request word goes through execute, head read and response load.
module mlpf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output mlpf_pkg::cmd_t     cmd
);
	import mlpf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_full_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		req_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				// Load the output register once it is free or being emptied.
				if (!out_full_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Occupancy of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (rsp_ready) begin
			out_full_q <= 1'b0;
		end
	end

	assign rsp_valid = out_full_q;

endmodule

`default_nettype wire

[rtl/core/mlpf_datapath.sv]
`default_nettype none

`include "multilevel_priority_fifo_defines.svh"

// Level pointers, fill counts, entry RAM and response register.
module mlpf_datapath #(
	parameter int NUM_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mlpf_pkg::cmd_t       cmd,
	input  wire mlpf_pkg::req_word_t  req_word,
	output mlpf_pkg::rsp_word_t       rsp_word
);
	import mlpf_pkg::*;

	localparam int CAP = NUM_LEVELS * LEVEL_DEPTH;
	localparam int LIW = $clog2(NUM_LEVELS);
	localparam int IW  = $clog2(LEVEL_DEPTH);
	localparam int FW  = $clog2(LEVEL_DEPTH + 1);
	localparam int AW  = $clog2(CAP);
	localparam int TW  = $clog2(CAP + 1);
	localparam int SW  = (ID_BITS < 16) ? ID_BITS : 16;

	// Latched request.
	logic [1:0]    op_q;
	logic [3:0]    pri_q;
	logic [SW-1:0] id_q;

	// Per-level state.
	logic [FW-1:0] fill_q [NUM_LEVELS];
	logic [IW-1:0] head_q [NUM_LEVELS];
	logic [IW-1:0] tail_q [NUM_LEVELS];
	logic [TW-1:0] total_q;

	// Per-word results.
	status_t       status_q;
	logic          popped_q;
	logic          rep_valid_q;
	logic [3:0]    rep_pri_q;

	logic          in_range;
	logic [LIW-1:0] lv_pri;
	logic          busy_any;
	logic [LIW-1:0] busy_lv;
	logic [3:0]    busy_pri;
	status_t       status_d;
	logic          push_ok;
	logic          pop_ok;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;
	logic [FW-1:0] lvl_fill;
	rsp_word_t     out_word_q;

	function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] idx);
		return (idx == IW'(LEVEL_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// Named level and its range check.
	assign in_range = (pri_q != 4'd0) && (32'(pri_q) <= NUM_LEVELS);
	assign lv_pri   = LIW'(32'(pri_q) - 1);

	// Priority encoder: most urgent level that holds a task.
	always_comb begin
		busy_any = 1'b0;
		busy_lv  = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				busy_any = 1'b1;
				busy_lv  = LIW'(i);
			end
		end
	end

	assign busy_pri = 4'(32'(busy_lv) + 1);

	// Outcome of the latched operation.
	always_comb begin
		status_d = STAT_OK;
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		unique case (op_q)
			OP_PUSH: begin
				priority if (!in_range) begin
					status_d = STAT_RANGE;
				end else if (fill_q[lv_pri] >= FW'(LEVEL_DEPTH)) begin
					status_d = STAT_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			OP_POP: begin
				if (!busy_any) begin
					status_d = STAT_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			default: begin
				if (!in_range) begin
					status_d = STAT_RANGE;
				end
			end
		endcase
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= req_word.operation;
			pri_q <= req_word.priority_req;
			id_q  <= SW'(req_word.task_id);
		end
	end

	// Level pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			total_q <= '0;
		end else if (cmd.exec) begin
			if (push_ok) begin
				tail_q[lv_pri] <= wrap_next(tail_q[lv_pri]);
				fill_q[lv_pri] <= fill_q[lv_pri] + 1'b1;
				total_q        <= total_q + 1'b1;
			end
			if (pop_ok) begin
				head_q[busy_lv] <= wrap_next(head_q[busy_lv]);
				fill_q[busy_lv] <= fill_q[busy_lv] - 1'b1;
				total_q         <= total_q - 1'b1;
			end
		end
	end

	// Reported task: the popped head, or else the head after the operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= STAT_OK;
			popped_q    <= 1'b0;
			rep_valid_q <= 1'b0;
			rep_pri_q   <= '0;
		end else if (cmd.exec) begin
			status_q    <= status_d;
			popped_q    <= pop_ok;
			rep_valid_q <= pop_ok;
			rep_pri_q   <= busy_pri;
		end else if (cmd.read && !popped_q) begin
			rep_valid_q <= busy_any;
			rep_pri_q   <= busy_pri;
		end
	end

	// Entry RAM addressing: level times depth plus slot.
	assign ram_we    = cmd.exec && push_ok;
	assign ram_waddr = AW'(32'(lv_pri) * LEVEL_DEPTH + 32'(tail_q[lv_pri]));
	assign ram_re    = (cmd.exec && pop_ok) || (cmd.read && !popped_q);
	assign ram_raddr = AW'(32'(busy_lv) * LEVEL_DEPTH + 32'(head_q[busy_lv]));

	mlpf_ram #(
		.WIDTH (SW),
		.DEPTH (CAP)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (id_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Count held at the named level.
	assign lvl_fill = in_range ? fill_q[lv_pri] : '0;

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_word_q.status       <= status_q;
			out_word_q.out_valid    <= rep_valid_q;
			out_word_q.out_task_id  <= rep_valid_q ? 16'(ram_rdata) : 16'd0;
			out_word_q.out_priority <= rep_valid_q ? rep_pri_q : 4'd0;
			out_word_q.all_empty    <= (total_q == '0);
			out_word_q.total_count  <= 8'(32'(total_q));
			out_word_q.level_count  <= 5'(32'(lvl_fill));
		end
	end

	assign rsp_word = out_word_q;

	`MLPF_ASSERT_ALWAYS(a_total_cap, 32'(total_q) <= CAP)
	`MLPF_ASSERT_NEXT(a_push_count, cmd.exec && push_ok, 32'(total_q) == 32'($past(total_q)) + 1)
	`MLPF_ASSERT_NEXT(a_head_report, cmd.read && !popped_q, rep_valid_q == (total_q != '0))
	`MLPF_ASSERT_IMP(a_pop_nonempty, cmd.exec && pop_ok, total_q != '0)

endmodule

`default_nettype wire

[rtl/core/multilevel_priority_fifo.sv]
// Channel  Role    Word fields
// req      sink    operation, priority_req, task_id
// rsp      source  status, out_valid, out_task_id, out_priority, all_empty,
//                  total_count, level_count
//
// Each request word goes through accept, execute, head read from the
// entry RAM, response load. The single read port of the entry RAM sets this.
// Reset is asynchronous and active low; it empties every level at once.
// A response that is not taken holds in the output register; the block accepts
// the next request meanwhile and waits before loading its response.
`default_nettype none

module multilevel_priority_fifo #(
	parameter int NUM_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mlpf_req_if.sink  req,
	mlpf_rsp_if.source rsp
);
	import mlpf_pkg::*;

	cmd_t      cmd;
	logic      req_ready;
	logic      rsp_valid;
	rsp_word_t rsp_word;

	mlpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	mlpf_datapath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_word (req.data),
		.rsp_word (rsp_word)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_word;

endmodule

`default_nettype wire
